[hdl/llbps_pkg.sv]
// ----------------------------------------------------------------------------
// llbps_pkg: shared types for the least-load backup pair selector
// Field widths, the score width and the request and result structs, plus the
// (score, id) ordering function that the back end uses.
// ----------------------------------------------------------------------------
package llbps_pkg;

  localparam int unsigned NodeIdBits = 16;
  localparam int unsigned CountBits  = 16;
  localparam int unsigned WeightBits = 16;
  // backup + weight * recovery never exceeds this width.
  localparam int unsigned ScoreBits  = WeightBits + CountBits + 1;

  localparam logic [WeightBits-1:0] WeightReset = WeightBits'(1);

  typedef struct packed {
    logic [NodeIdBits-1:0] node_id;
    logic [CountBits-1:0]  backup_count;
    logic [CountBits-1:0]  recovery_count;
    logic                  one_hop;
    logic                  eligible;
    logic                  last_candidate;
  } req_t;

  typedef struct packed {
    logic                  found;
    logic [NodeIdBits-1:0] local_node;
    logic [NodeIdBits-1:0] remote_node;
  } res_t;

  // A scored candidate as it travels from the front end to the back end.
  typedef struct packed {
    logic [ScoreBits-1:0]  score;
    logic [NodeIdBits-1:0] node_id;
    logic                  one_hop;
    logic                  eligible;
    logic                  last_candidate;
  } item_t;

  // True when (score_a, id_a) orders strictly before (score_b, id_b).
  function automatic logic key_less(logic [ScoreBits-1:0]  score_a,
                                    logic [NodeIdBits-1:0] id_a,
                                    logic [ScoreBits-1:0]  score_b,
                                    logic [NodeIdBits-1:0] id_b);
    logic lt;
    if (score_a != score_b) begin
      lt = score_a < score_b;
    end else begin
      lt = id_a < id_b;
    end
    return lt;
  endfunction

endpackage

[hdl/least_load_backup_pair_select_unit.sv]
// Path: a request passes the front register, the queue and the result register in
// that order, and a result is valid once the last request of a set has passed them.
// Throughput: one request per cycle while the queue is not full; the score
// multiplier and the minima compare each take one stage, and the queue absorbs
// back-pressure. Reset: clears the minima, the queue and the result valid flag,
// and sets the recovery weight to 1.
// ----------------------------------------------------------------------------
// least_load_backup_pair_select_unit: least-load backup pair selector
// Scores a stream of candidate nodes and returns the least-loaded one-hop node
// and the least-loaded other node at the end of each set.
// ----------------------------------------------------------------------------
module least_load_backup_pair_select_unit #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [llbps_pkg::WeightBits-1:0] cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  llbps_pkg::req_t                  in_req_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output llbps_pkg::res_t                  out_res_o
);

  logic             f_valid, f_ready, b_valid, b_ready;
  llbps_pkg::item_t f_item, b_item;

  llbps_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .item_valid_o(f_valid),
    .item_ready_i(f_ready),
    .item_o      (f_item)
  );

  llbps_queue #(
    .Depth(QUEUE_DEPTH)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(f_valid),
    .wr_ready_o(f_ready),
    .wr_item_i (f_item),
    .rd_valid_o(b_valid),
    .rd_ready_i(b_ready),
    .rd_item_o (b_item)
  );

  llbps_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(b_valid),
    .item_ready_o(b_ready),
    .item_i      (b_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (out_res_o)
  );

endmodule

[hdl/llbps_front.sv]
// ----------------------------------------------------------------------------
// llbps_front: request intake and load scoring
// Holds the recovery weight, accepts one request per cycle unless stalled and
// registers the candidate with its load score backup + weight * recovery.
// ----------------------------------------------------------------------------
module llbps_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [llbps_pkg::WeightBits-1:0]   cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  llbps_pkg::req_t                    in_req_i,
  output logic                               item_valid_o,
  input  logic                               item_ready_i,
  output llbps_pkg::item_t                   item_o
);

  localparam int unsigned ProdBits = llbps_pkg::WeightBits + llbps_pkg::CountBits;

  logic [llbps_pkg::WeightBits-1:0] weight_q;
  logic                             valid_q;
  llbps_pkg::item_t                 item_d, item_q;
  logic [ProdBits-1:0]              prod;

  assign prod = ProdBits'(weight_q) * ProdBits'(in_req_i.recovery_count);

  always_comb begin
    item_d.score          = llbps_pkg::ScoreBits'(prod)
                          + llbps_pkg::ScoreBits'(in_req_i.backup_count);
    item_d.node_id        = in_req_i.node_id;
    item_d.one_hop        = in_req_i.one_hop;
    item_d.eligible       = in_req_i.eligible;
    item_d.last_candidate = in_req_i.last_candidate;
  end

  assign in_ready_o   = !valid_q || item_ready_i;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q <= llbps_pkg::WeightReset;
      valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        weight_q <= cfg_wdata_i;
      end
      if (in_ready_o) begin
        valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_d;
    end
  end

endmodule

[hdl/llbps_queue.sv]
// ----------------------------------------------------------------------------
// llbps_queue: short queue between front and back end
// A small circular buffer of scored candidates so that the intake and the
// selection stages can stall independently.
// ----------------------------------------------------------------------------
module llbps_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  llbps_pkg::item_t wr_item_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output llbps_pkg::item_t rd_item_o
);

  localparam int unsigned PtrBits = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntBits = $clog2(Depth + 1);

  llbps_pkg::item_t   entries_q [Depth];
  logic [PtrBits-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0] count_q, count_d;
  logic               push, pop;

  assign wr_ready_o = count_q != CntBits'(Depth);
  assign rd_valid_o = count_q != '0;
  assign rd_item_o  = entries_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrBits'(Depth - 1)) ? '0 : wr_ptr_q + PtrBits'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrBits'(Depth - 1)) ? '0 : rd_ptr_q + PtrBits'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CntBits'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= wr_item_i;
    end
  end

endmodule

[hdl/llbps_back.sv]
// ----------------------------------------------------------------------------
// llbps_back: running minima and result register
// Tracks the two smallest eligible candidates and the smallest eligible
// one-hop candidate, and forms the local/remote pair on the last request.
// ----------------------------------------------------------------------------
module llbps_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             item_valid_i,
  output logic             item_ready_o,
  input  llbps_pkg::item_t item_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output llbps_pkg::res_t  out_res_o
);

  typedef struct packed {
    logic [llbps_pkg::ScoreBits-1:0]  score;
    logic [llbps_pkg::NodeIdBits-1:0] node;
    logic                             valid;
  } slot_t;

  slot_t           best_q, best_d, next_q, next_d, hop_q, hop_d;
  logic            out_valid_q;
  llbps_pkg::res_t res_q, res_d;
  logic            pop;

  // Only a last request needs room in the result register.
  assign item_ready_o = !item_i.last_candidate || !out_valid_q || out_ready_i;
  assign pop          = item_valid_i && item_ready_o;
  assign out_valid_o  = out_valid_q;
  assign out_res_o    = res_q;

  always_comb begin
    best_d = best_q;
    next_d = next_q;
    hop_d  = hop_q;
    if (item_i.eligible) begin
      if (!best_q.valid || llbps_pkg::key_less(item_i.score, item_i.node_id,
                                               best_q.score, best_q.node)) begin
        next_d = best_q;
        best_d = '{score: item_i.score, node: item_i.node_id, valid: 1'b1};
      end else if (!next_q.valid || llbps_pkg::key_less(item_i.score, item_i.node_id,
                                                        next_q.score, next_q.node)) begin
        next_d = '{score: item_i.score, node: item_i.node_id, valid: 1'b1};
      end
      if (item_i.one_hop && (!hop_q.valid || llbps_pkg::key_less(
            item_i.score, item_i.node_id, hop_q.score, hop_q.node))) begin
        hop_d = '{score: item_i.score, node: item_i.node_id, valid: 1'b1};
      end
    end

    // The remote node is the smallest eligible candidate that is not the local one.
    res_d = '0;
    if (hop_d.valid) begin
      if (best_d.valid && best_d.node != hop_d.node) begin
        res_d.found       = 1'b1;
        res_d.local_node  = hop_d.node;
        res_d.remote_node = best_d.node;
      end else if (next_d.valid && next_d.node != hop_d.node) begin
        res_d.found       = 1'b1;
        res_d.local_node  = hop_d.node;
        res_d.remote_node = next_d.node;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q      <= '0;
      next_q      <= '0;
      hop_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        if (item_i.last_candidate) begin
          best_q <= '0;
          next_q <= '0;
          hop_q  <= '0;
        end else begin
          best_q <= best_d;
          next_q <= next_d;
          hop_q  <= hop_d;
        end
      end
      if (pop && item_i.last_candidate) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && item_i.last_candidate) begin
      res_q <= res_d;
    end
  end

`ifndef SYNTHESIS
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && item_i.last_candidate |=> !best_q.valid && !next_q.valid && !hop_q.valid)
    else $error("minima not cleared after the last request of a set");

  a_next_needs_best: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_q.valid |-> best_q.valid)
    else $error("second-smallest slot valid without a smallest slot");

  a_hop_needs_best: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hop_q.valid |-> best_q.valid)
    else $error("one-hop slot valid without a smallest slot");

  a_pair_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.found |-> res_q.local_node != res_q.remote_node)
    else $error("local and remote node are the same");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(res_q))
    else $error("result register changed while stalled");
`endif

endmodule
